[design/preemptive_priority_scheduler_defines.svh]
// Assertion macros for the scheduler sequencer (pps_ctrl).
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pps_pkg.sv]
// Shared types and constants of the preemptive priority scheduler.
// No dependencies; pps_pick, pps_ctrl and the top level refer to it by scoped names.
package pps_pkg;

  localparam int unsigned MAX_TASKS = 16;
  localparam int unsigned IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int unsigned CLK_W     = 24;
  localparam logic [CLK_W-1:0] CLOCK_MAX = {CLK_W{1'b1}};

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_ZERO = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_FIN
  } state_t;

  // One task table entry as held in memory.
  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic        done;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Scan control towards the selection unit.
  typedef struct packed {
    logic             clr;
    logic             vld;
    logic [IDX_W-1:0] idx;
  } scan_t;

  // Best candidate found so far.
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } best_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [4:0]       running_task;
    logic [CLK_W-1:0] time_now;
    logic             task_finished;
    logic [CLK_W-1:0] finish_time;
    logic [CLK_W-1:0] turnaround;
    logic [CLK_W-1:0] waiting;
    logic             all_done;
  } result_t;

endpackage

[design/pps_task_mem.sv]
// Task table memory: one write port, one read port, registered read data.
// Generic; no package dependency.
module pps_task_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 57
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/pps_pick.sv]
// Selection unit: keeps the best eligible task seen during a table scan.
// Depends on pps_pkg for the entry, scan and best-candidate types.
module pps_pick (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pps_pkg::scan_t          scan,
  input  pps_pkg::entry_t         cand,
  input  logic [pps_pkg::CLK_W-1:0] clock_now,
  output pps_pkg::best_t          best
);

  logic                      vld_r;
  logic [pps_pkg::IDX_W-1:0] idx_r;
  pps_pkg::entry_t           ent_r;
  logic                      eligible;
  logic                      better;
  logic                      take;

  assign eligible = !cand.done &&
                    ({{(pps_pkg::CLK_W-16){1'b0}}, cand.arrival} <= clock_now);
  // strict compares: a full tie keeps the earlier slot
  assign better   = !vld_r || (cand.prio < ent_r.prio) ||
                    ((cand.prio == ent_r.prio) && (cand.arrival < ent_r.arrival));
  assign take     = scan.vld && eligible && better;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (scan.clr) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !scan.clr) begin
      idx_r <= scan.idx;
      ent_r <= cand;
    end
  end

  assign best = '{vld: vld_r, idx: idx_r, entry: ent_r};

endmodule

[design/pps_ctrl.sv]
// Sequencer: loads, table scan, read-modify-write of the served task, result.
// Depends on pps_pkg and the assertion macros header.
`include "preemptive_priority_scheduler_defines.svh"

module pps_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      in_opcode,
  input  logic [7:0]                in_task_priority,
  input  logic [15:0]               in_task_arrival,
  input  logic [15:0]               in_task_burst,
  output logic                      busy,
  output logic                      wr_en,
  output logic [pps_pkg::IDX_W-1:0] wr_addr,
  output pps_pkg::entry_t           wr_data,
  output logic                      rd_en,
  output logic [pps_pkg::IDX_W-1:0] rd_addr,
  output pps_pkg::scan_t            scan,
  output logic [pps_pkg::CLK_W-1:0] clock_now,
  input  pps_pkg::best_t            best,
  output logic                      res_vld,
  output pps_pkg::result_t          res
);

  pps_pkg::state_t           state_r, state_nxt;
  logic [pps_pkg::CNT_W-1:0] loaded_r, loaded_nxt;
  logic [pps_pkg::CNT_W-1:0] finished_r, finished_nxt;
  logic [pps_pkg::CLK_W-1:0] clock_r, clock_nxt;
  logic [pps_pkg::CNT_W-1:0] issue_r, issue_nxt;
  logic                      pend_r, pend_nxt;
  logic [pps_pkg::IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic                      fin_r, fin_nxt;
  logic [pps_pkg::CLK_W-1:0] tat_r, tat_nxt;
  logic [15:0]               rem_dec;
  logic [pps_pkg::CLK_W-1:0] burst_ext;

  assign rem_dec   = best.entry.remaining - 16'd1;
  assign burst_ext = {{(pps_pkg::CLK_W-16){1'b0}}, best.entry.burst};
  assign clock_now = clock_r;
  assign busy      = (state_r != pps_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pps_pkg::S_IDLE;
      loaded_r   <= '0;
      finished_r <= '0;
      clock_r    <= '0;
      issue_r    <= '0;
      pend_r     <= 1'b0;
      fin_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      loaded_r   <= loaded_nxt;
      finished_r <= finished_nxt;
      clock_r    <= clock_nxt;
      issue_r    <= issue_nxt;
      pend_r     <= pend_nxt;
      fin_r      <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    tat_r      <= tat_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    loaded_nxt   = loaded_r;
    finished_nxt = finished_r;
    clock_nxt    = clock_r;
    issue_nxt    = issue_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = pend_idx_r;
    fin_nxt      = fin_r;
    tat_nxt      = tat_r;
    wr_en        = 1'b0;
    wr_addr      = best.idx;
    wr_data      = best.entry;
    rd_en        = 1'b0;
    rd_addr      = issue_r[pps_pkg::IDX_W-1:0];
    scan         = '{clr: 1'b0, vld: pend_r, idx: pend_idx_r};
    res_vld      = 1'b0;
    res          = '0;
    res.time_now = clock_r;

    unique case (state_r)
      pps_pkg::S_IDLE: begin
        if (start) begin
          if (in_opcode == pps_pkg::OP_LOAD) begin
            res_vld = 1'b1;
            if (loaded_r >= pps_pkg::CNT_W'(pps_pkg::MAX_TASKS)) begin
              res.status = pps_pkg::STATUS_FULL;
            end else if (in_task_burst == 16'd0) begin
              res.status = pps_pkg::STATUS_ZERO;
            end else begin
              res.status = pps_pkg::STATUS_OK;
              wr_en      = 1'b1;
              wr_addr    = loaded_r[pps_pkg::IDX_W-1:0];
              wr_data    = '{prio: in_task_priority, arrival: in_task_arrival,
                             burst: in_task_burst, remaining: in_task_burst,
                             done: 1'b0};
              loaded_nxt = loaded_r + 1'b1;
            end
            res.all_done = (finished_r == loaded_nxt);
          end else begin
            issue_nxt = '0;
            scan.clr  = 1'b1;
            state_nxt = pps_pkg::S_SCAN;
          end
        end
      end

      pps_pkg::S_SCAN: begin
        // one read per cycle; data is compared the cycle after
        if (issue_r < loaded_r) begin
          rd_en        = 1'b1;
          issue_nxt    = issue_r + 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = issue_r[pps_pkg::IDX_W-1:0];
        end else begin
          state_nxt = pps_pkg::S_UPDATE;
        end
      end

      pps_pkg::S_UPDATE: begin
        clock_nxt = (clock_r == pps_pkg::CLOCK_MAX) ? clock_r : clock_r + 1'b1;
        fin_nxt   = 1'b0;
        if (best.vld) begin
          wr_en                   = 1'b1;
          wr_data.remaining       = rem_dec;
          wr_data.done            = (rem_dec == 16'd0);
          if (rem_dec == 16'd0) begin
            fin_nxt      = 1'b1;
            finished_nxt = finished_r + 1'b1;
            tat_nxt      = clock_nxt -
                           {{(pps_pkg::CLK_W-16){1'b0}}, best.entry.arrival};
          end
        end
        state_nxt = pps_pkg::S_FIN;
      end

      pps_pkg::S_FIN: begin
        res_vld            = 1'b1;
        res.status         = pps_pkg::STATUS_OK;
        res.running_task   = best.vld ? 5'({1'b0, best.idx} + 1'b1) : 5'd0;
        res.task_finished  = fin_r;
        if (fin_r) begin
          res.finish_time = clock_r;
          res.turnaround  = tat_r;
          res.waiting     = (tat_r >= burst_ext) ? tat_r - burst_ext : '0;
        end
        res.all_done = (finished_r == loaded_r);
        state_nxt    = pps_pkg::S_IDLE;
      end

      default: begin
        state_nxt = pps_pkg::S_IDLE;
      end
    endcase
  end

  `PPS_ASSERT_NOW(a_loaded_bound, 1'b1, loaded_r <= pps_pkg::CNT_W'(pps_pkg::MAX_TASKS), "table count beyond capacity")
  `PPS_ASSERT_NOW(a_finished_bound, 1'b1, finished_r <= loaded_r, "more tasks finished than loaded")
  `PPS_ASSERT_NOW(a_pick_live, state_r == pps_pkg::S_UPDATE && best.vld, !best.entry.done && best.entry.remaining != 16'd0, "served task already complete")
  `PPS_ASSERT_NEXT(a_result_idle, res_vld, state_r == pps_pkg::S_IDLE, "sequencer busy after result")

endmodule

[design/preemptive_priority_scheduler.sv]
// Top level of the preemptive priority scheduler: task table, sequencer,
// selection unit and the result register. Depends on pps_pkg.
//
//   port group   direction  handshake           contents
//   in_*         in         start / busy        opcode, task priority, arrival, burst
//   out_*        out        out_valid strobe    status, served task, times, all done
//
// A load is accepted in idle; its result strobes in the next cycle.
// A tick holds busy while it scans the N loaded tasks (at most 16), updates the
// served task and gives its result: the single read port of the task table returns one entry per cycle.
// Reset (synchronous, active low) clears the loaded count, so the table counts as empty; only loaded slots are read.
// Results cannot be held off; a new item may be started while a strobe shows.
module preemptive_priority_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [7:0]  in_task_priority,
  input  logic [15:0] in_task_arrival,
  input  logic [15:0] in_task_burst,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [4:0]  out_running_task,
  output logic [23:0] out_time_now,
  output logic        out_task_finished,
  output logic [23:0] out_finish_time,
  output logic [23:0] out_turnaround,
  output logic [23:0] out_waiting,
  output logic        out_all_done
);

  logic                      wr_en;
  logic [pps_pkg::IDX_W-1:0] wr_addr;
  pps_pkg::entry_t           wr_data;
  logic                      rd_en;
  logic [pps_pkg::IDX_W-1:0] rd_addr;
  logic [pps_pkg::ENTRY_W-1:0] rd_data;
  pps_pkg::scan_t            scan;
  logic [pps_pkg::CLK_W-1:0] clock_now;
  pps_pkg::best_t            best;
  logic                      res_vld;
  pps_pkg::result_t          res;
  logic                      out_valid_r;
  pps_pkg::result_t          out_r;

  pps_task_mem #(
    .DEPTH  (pps_pkg::MAX_TASKS),
    .ADDR_W (pps_pkg::IDX_W),
    .DATA_W (pps_pkg::ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pps_pick u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .scan      (scan),
    .cand      (pps_pkg::entry_t'(rd_data)),
    .clock_now (clock_now),
    .best      (best)
  );

  pps_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_opcode        (in_opcode),
    .in_task_priority (in_task_priority),
    .in_task_arrival  (in_task_arrival),
    .in_task_burst    (in_task_burst),
    .busy             (busy),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .scan             (scan),
    .clock_now        (clock_now),
    .best             (best),
    .res_vld          (res_vld),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_running_task  = out_r.running_task;
  assign out_time_now      = out_r.time_now;
  assign out_task_finished = out_r.task_finished;
  assign out_finish_time   = out_r.finish_time;
  assign out_turnaround    = out_r.turnaround;
  assign out_waiting       = out_r.waiting;
  assign out_all_done      = out_r.all_done;

endmodule

[test/preemptive_priority_scheduler_tb.sv]
// Self-checking testbench for preemptive_priority_scheduler: a directed table, then random
// load and tick items, each result checked against a behavioural scheduler model or a typed row's expectation.
// Depends on pps_pkg and the preemptive_priority_scheduler RTL.
module preemptive_priority_scheduler_tb;

  typedef struct packed {
    logic       op;
    logic [7:0] prio;
    logic [15:0] arr;
    logic [15:0] burst;
    logic       typed;
    pps_pkg::result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_opcode;
  logic [7:0]  in_task_priority;
  logic [15:0] in_task_arrival;
  logic [15:0] in_task_burst;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [4:0]  out_running_task;
  logic [23:0] out_time_now;
  logic        out_task_finished;
  logic [23:0] out_finish_time;
  logic [23:0] out_turnaround;
  logic [23:0] out_waiting;
  logic        out_all_done;

  // Typed expectation travelling with the item on the input side
  logic             drv_typed;
  pps_pkg::result_t drv_res;

  // Scheduler model state
  logic [7:0]  tbl_prio  [pps_pkg::MAX_TASKS];
  logic [15:0] tbl_arr   [pps_pkg::MAX_TASKS];
  logic [15:0] tbl_burst [pps_pkg::MAX_TASKS];
  logic [15:0] tbl_left  [pps_pkg::MAX_TASKS];
  logic        tbl_done  [pps_pkg::MAX_TASKS];
  int          loaded_cnt = 0;
  int          finished_cnt = 0;
  logic [23:0] sched_clock = '0;

  pps_pkg::result_t expected_results[$];
  stim_row_t        directed_rows[$];
  int               errors = 0;
  bit               quiet = 0;

  preemptive_priority_scheduler i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_task_priority  (in_task_priority),
    .in_task_arrival   (in_task_arrival),
    .in_task_burst     (in_task_burst),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_running_task  (out_running_task),
    .out_time_now      (out_time_now),
    .out_task_finished (out_task_finished),
    .out_finish_time   (out_finish_time),
    .out_turnaround    (out_turnaround),
    .out_waiting       (out_waiting),
    .out_all_done      (out_all_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("preemptive_priority_scheduler_tb: FAIL");
    $finish;
  end

  // Advance the scheduler model by one item and return the result it gives
  function automatic pps_pkg::result_t predict_schedule(input logic op,
                                                        input logic [7:0] prio,
                                                        input logic [15:0] arr,
                                                        input logic [15:0] burst);
    pps_pkg::result_t r;
    int               sel;
    logic [23:0]      tat;
    r = '0;
    if (op == pps_pkg::OP_LOAD) begin
      if (loaded_cnt >= pps_pkg::MAX_TASKS) begin
        r.status = pps_pkg::STATUS_FULL;
      end else if (burst == 16'd0) begin
        r.status = pps_pkg::STATUS_ZERO;
      end else begin
        tbl_prio[loaded_cnt]  = prio;
        tbl_arr[loaded_cnt]   = arr;
        tbl_burst[loaded_cnt] = burst;
        tbl_left[loaded_cnt]  = burst;
        tbl_done[loaded_cnt]  = 1'b0;
        loaded_cnt++;
      end
    end else begin
      sel = -1;
      for (int i = 0; i < loaded_cnt; i++) begin
        if (tbl_done[i] || 24'(tbl_arr[i]) > sched_clock) continue;
        // smaller priority, then earlier arrival, then earlier slot
        if (sel < 0 || tbl_prio[i] < tbl_prio[sel] ||
            (tbl_prio[i] == tbl_prio[sel] && tbl_arr[i] < tbl_arr[sel]))
          sel = i;
      end
      if (sched_clock != pps_pkg::CLOCK_MAX) sched_clock++;
      if (sel >= 0) begin
        r.running_task = 5'(sel + 1);
        tbl_left[sel]  = tbl_left[sel] - 16'd1;
        if (tbl_left[sel] == 16'd0) begin
          tbl_done[sel] = 1'b1;
          finished_cnt++;
          r.task_finished = 1'b1;
          r.finish_time   = sched_clock;
          tat             = sched_clock - 24'(tbl_arr[sel]);
          r.turnaround    = tat;
          r.waiting       = (tat >= 24'(tbl_burst[sel])) ? tat - 24'(tbl_burst[sel]) : '0;
        end
      end
    end
    r.time_now = sched_clock;
    r.all_done = (finished_cnt == loaded_cnt);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [23:0] exp_v,
                             input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Check results and record accepted items; check first, a strobe may share the edge
  always @(posedge clk) begin : result_mon
    pps_pkg::result_t res;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no item pending, actual status %0d time %0d",
                   $time, out_status, out_time_now);
          errors++;
        end else begin
          res = expected_results.pop_front();
          check_field("status", 24'(res.status), 24'(out_status));
          check_field("running_task", 24'(res.running_task), 24'(out_running_task));
          check_field("time_now", res.time_now, out_time_now);
          check_field("task_finished", 24'(res.task_finished), 24'(out_task_finished));
          check_field("finish_time", res.finish_time, out_finish_time);
          check_field("turnaround", res.turnaround, out_turnaround);
          check_field("waiting", res.waiting, out_waiting);
          check_field("all_done", 24'(res.all_done), 24'(out_all_done));
        end
      end
      if (start && !busy) begin
        res = predict_schedule(in_opcode, in_task_priority, in_task_arrival, in_task_burst);
        if (drv_typed) res = drv_res;
        expected_results.push_back(res);
      end
    end
  end

  function automatic void add_row(input logic op, input logic [7:0] prio,
                                  input logic [15:0] arr, input logic [15:0] burst,
                                  input logic typed, input pps_pkg::status_t st,
                                  input logic [4:0] running, input logic [23:0] now,
                                  input logic fin, input logic [23:0] ftime,
                                  input logic [23:0] tat, input logic [23:0] wt,
                                  input logic all_done);
    stim_row_t row;
    row.op                = op;
    row.prio              = prio;
    row.arr               = arr;
    row.burst             = burst;
    row.typed             = typed;
    row.res.status        = st;
    row.res.running_task  = running;
    row.res.time_now      = now;
    row.res.task_finished = fin;
    row.res.finish_time   = ftime;
    row.res.turnaround    = tat;
    row.res.waiting       = wt;
    row.res.all_done      = all_done;
    directed_rows.push_back(row);
  endfunction

  // Present one item after a random gap and hold it until accepted
  task automatic send_item(input logic op, input logic [7:0] prio, input logic [15:0] arr,
                           input logic [15:0] burst, input logic typed,
                           input pps_pkg::result_t res);
    int gap;
    if ($urandom_range(0, 19) == 0) quiet = !quiet;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_opcode        <= op;
    in_task_priority <= prio;
    in_task_arrival  <= arr;
    in_task_burst    <= burst;
    drv_typed        <= typed;
    drv_res          <= res;
    do @(posedge clk); while (busy);
  endtask

  initial begin : stimulus
    int          kind;
    logic [7:0]  prio;
    logic [15:0] arr;
    logic [15:0] burst;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_opcode        <= pps_pkg::OP_LOAD;
    in_task_priority <= '0;
    in_task_arrival  <= '0;
    in_task_burst    <= '0;
    drv_typed        <= 1'b0;
    drv_res          <= '0;

    // op, prio, arrival, burst, typed,
    //   status, running, time, fin, ftime, tat, wait, all_done
    add_row(pps_pkg::OP_TICK, 8'd0,   16'd0,     16'd0, 1,
            pps_pkg::STATUS_OK,   0, 1, 0, 0, 0, 0, 1); // empty
    add_row(pps_pkg::OP_LOAD, 8'd255, 16'd65535, 16'd0, 1,
            pps_pkg::STATUS_ZERO, 0, 1, 0, 0, 0, 0, 1);
    add_row(pps_pkg::OP_LOAD, 8'd0,   16'd0,     16'd1, 1,
            pps_pkg::STATUS_OK,   0, 1, 0, 0, 0, 0, 0);
    add_row(pps_pkg::OP_TICK, 8'd0,   16'd0,     16'd0, 1,
            pps_pkg::STATUS_OK,   1, 2, 1, 2, 2, 1, 1);
    add_row(pps_pkg::OP_LOAD, 8'd255, 16'd0,     16'd4, 1,
            pps_pkg::STATUS_OK,   0, 2, 0, 0, 0, 0, 0);
    // equal priorities: earlier arrival wins, then earlier slot
    add_row(pps_pkg::OP_LOAD, 8'd7,   16'd3,     16'd2, 0,
            pps_pkg::STATUS_OK,   0, 0, 0, 0, 0, 0, 0);
    add_row(pps_pkg::OP_LOAD, 8'd7,   16'd2,     16'd2, 0,
            pps_pkg::STATUS_OK,   0, 0, 0, 0, 0, 0, 0);
    add_row(pps_pkg::OP_LOAD, 8'd7,   16'd2,     16'd1, 0,
            pps_pkg::STATUS_OK,   0, 0, 0, 0, 0, 0, 0);
    add_row(pps_pkg::OP_TICK, 8'd0,   16'd0,     16'd0, 0,
            pps_pkg::STATUS_OK,   0, 0, 0, 0, 0, 0, 0);
    add_row(pps_pkg::OP_TICK, 8'hff,  16'hffff,  16'hffff, 0,
            pps_pkg::STATUS_OK,   0, 0, 0, 0, 0, 0, 0);
    add_row(pps_pkg::OP_TICK, 8'd0,   16'd0,     16'd0, 0,
            pps_pkg::STATUS_OK,   0, 0, 0, 0, 0, 0, 0);
    // late load with a past arrival preempts at once
    add_row(pps_pkg::OP_LOAD, 8'd0,   16'd1,     16'd3, 0,
            pps_pkg::STATUS_OK,   0, 0, 0, 0, 0, 0, 0);
    add_row(pps_pkg::OP_TICK, 8'd0,   16'd0,     16'd0, 0,
            pps_pkg::STATUS_OK,   0, 0, 0, 0, 0, 0, 0);
    add_row(pps_pkg::OP_TICK, 8'd0,   16'd0,     16'd0, 0,
            pps_pkg::STATUS_OK,   0, 0, 0, 0, 0, 0, 0);
    add_row(pps_pkg::OP_TICK, 8'd0,   16'd0,     16'd0, 0,
            pps_pkg::STATUS_OK,   0, 0, 0, 0, 0, 0, 0);
    add_row(pps_pkg::OP_TICK, 8'd0,   16'd0,     16'd0, 0,
            pps_pkg::STATUS_OK,   0, 0, 0, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].prio, directed_rows[i].arr,
                directed_rows[i].burst, directed_rows[i].typed, directed_rows[i].res);

    for (int n = 0; n < 1350; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
        send_item(pps_pkg::OP_LOAD, 8'($urandom), 16'($urandom), 16'd0, 1'b0, '0);
      end else if (kind < 12) begin
        if (loaded_cnt < pps_pkg::MAX_TASKS) begin
          // narrow priorities and arrivals near the clock to provoke ties and preemption
          prio  = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
          arr   = $urandom_range(0, 1) ? 16'(sched_clock + $urandom_range(0, 60))
                                       : 16'($urandom_range(0, int'(sched_clock)));
          burst = 16'($urandom_range(1, 120));
        end else begin
          prio  = 8'($urandom);
          arr   = 16'($urandom);
          burst = 16'($urandom);
        end
        send_item(pps_pkg::OP_LOAD, prio, arr, burst, 1'b0, '0);
      end else begin
        send_item(pps_pkg::OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
      end
    end
    start <= 1'b0;

    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (25) @(posedge clk);
    if (errors == 0)
      $display("preemptive_priority_scheduler_tb: PASS");
    else
      $display("preemptive_priority_scheduler_tb: FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/pps_pkg.sv
design/pps_task_mem.sv
design/pps_pick.sv
design/pps_ctrl.sv
design/preemptive_priority_scheduler.sv
test/preemptive_priority_scheduler_tb.sv
